// File: sv/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types, constants and helpers for the programmable CRC engine.
// ----------------------------------------------------------------------------
package pce_pkg;

   // Widest CRC register the engine supports; the result field has this width.
   localparam int CRC_W     = 32;
   // Bits needed for a shift amount in 0 .. CRC_W-1.
   localparam int SHIFT_W   = $clog2(CRC_W);
   // Width of the crc_width register field.
   localparam int WIDTH_W   = 6;
   // Width of the register index on the configuration port.
   localparam int CSR_IDX_W = 3;

   // Reset values of the configuration registers.
   localparam logic [CRC_W-1:0] POLY_RST  = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0] INIT_RST  = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] FXOR_RST  = 32'hFFFF_FFFF;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRC_WIDTH      = 3'd0,
      CSR_POLYNOMIAL     = 3'd1,
      CSR_INITIAL_VALUE  = 3'd2,
      CSR_REFLECT_INPUT  = 3'd3,
      CSR_REFLECT_OUTPUT = 3'd4,
      CSR_FINAL_XOR      = 3'd5
   } csr_index_type;

   // Current settings as seen by the datapath.
   typedef struct packed {
      logic [SHIFT_W-1:0] shift;       // CRC_W minus effective width
      logic [CRC_W-1:0]   mask;        // ones over the effective width
      logic [CRC_W-1:0]   polynomial;
      logic [CRC_W-1:0]   initial_value;
      logic               reflect_input;
      logic               reflect_output;
      logic [CRC_W-1:0]   final_xor;
   } cfg_type;

   // Full-width bit reversal.
   function automatic logic [CRC_W-1:0] bit_reverse(input logic [CRC_W-1:0] v);
      logic [CRC_W-1:0] r;
      for (int i = 0; i < CRC_W; i++) begin
         r[i] = v[CRC_W-1-i];
      end
      return r;
   endfunction

endpackage

// File: sv/pce_csr.sv
// ----------------------------------------------------------------------------
// pce_csr
// Configuration register file; clamps the width and keeps its shift and mask.
// ----------------------------------------------------------------------------
module pce_csr
   import pce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CRC_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [WIDTH_W-1:0]   width_raw;
   logic [WIDTH_W-1:0]   width_eff;
   logic [WIDTH_W-1:0]   shift_full;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Width clamp: zero acts as one, anything above the maximum as the maximum
   assign width_raw  = csr_wdata[WIDTH_W-1:0];
   always_comb begin
      if (width_raw == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (width_raw > WIDTH_W'(CRC_W)) begin
         width_eff = WIDTH_W'(CRC_W);
      end else begin
         width_eff = width_raw;
      end
   end
   assign shift_full = WIDTH_W'(CRC_W) - width_eff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CRC_WIDTH: begin
               cfg_in.shift = shift_full[SHIFT_W-1:0];
               cfg_in.mask  = {CRC_W{1'b1}} >> shift_full[SHIFT_W-1:0];
            end
            CSR_POLYNOMIAL:     cfg_in.polynomial     = csr_wdata;
            CSR_INITIAL_VALUE:  cfg_in.initial_value  = csr_wdata;
            CSR_REFLECT_INPUT:  cfg_in.reflect_input  = csr_wdata[0];
            CSR_REFLECT_OUTPUT: cfg_in.reflect_output = csr_wdata[0];
            CSR_FINAL_XOR:      cfg_in.final_xor      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shift          <= '0;
         cfg_ff.mask           <= {CRC_W{1'b1}};
         cfg_ff.polynomial     <= POLY_RST;
         cfg_ff.initial_value  <= INIT_RST;
         cfg_ff.reflect_input  <= 1'b1;
         cfg_ff.reflect_output <= 1'b1;
         cfg_ff.final_xor      <= FXOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/pce_byte_step.sv
// ----------------------------------------------------------------------------
// pce_byte_step
// Eight bit-serial CRC steps for one byte, on a left-aligned CRC register.
// ----------------------------------------------------------------------------
module pce_byte_step
   import pce_pkg::*;
(
   input  logic [CRC_W-1:0] crc_in,      // register, MSB at the top bit
   input  logic [7:0]       data_byte,
   input  logic             reflect_input,
   input  logic [CRC_W-1:0] poly_aligned,
   output logic [CRC_W-1:0] crc_out
);

   // Shift each message bit in; top bit XOR message bit selects the polynomial
   always_comb begin
      logic [CRC_W-1:0] crc;
      logic             msg_bit;
      logic             fb;
      crc = crc_in;
      for (int j = 0; j < 8; j++) begin
         msg_bit = reflect_input ? data_byte[j] : data_byte[7-j];
         fb      = crc[CRC_W-1] ^ msg_bit;
         crc     = {crc[CRC_W-2:0], 1'b0};
         if (fb) begin
            crc = crc ^ poly_aligned;
         end
      end
      crc_out = crc;
   end

endmodule

// File: sv/pce_finish.sv
// ----------------------------------------------------------------------------
// pce_finish
// Output reflection and final XOR of a finished CRC register.
// ----------------------------------------------------------------------------
module pce_finish
   import pce_pkg::*;
(
   input  logic [CRC_W-1:0]   crc_aligned,  // left-aligned, zeros below width
   input  logic [SHIFT_W-1:0] shift,
   input  logic [CRC_W-1:0]   mask,
   input  logic               reflect_output,
   input  logic [CRC_W-1:0]   final_xor,
   output logic [CRC_W-1:0]   crc_result
);

   logic [CRC_W-1:0] crc_plain;
   logic [CRC_W-1:0] crc_refl;

   // Reversing the left-aligned word reflects within the active width
   assign crc_plain  = crc_aligned >> shift;
   assign crc_refl   = bit_reverse(crc_aligned);
   assign crc_result = ((reflect_output ? crc_refl : crc_plain) ^ final_xor) & mask;

endmodule

// File: sv/programmable_crc_engine.sv
// ----------------------------------------------------------------------------
// programmable_crc_engine
// Programmable CRC engine: bytes in with a last-byte flag, one CRC out per
// message, width 1..32, polynomial, init, reflections and final XOR settable.
// ----------------------------------------------------------------------------
//
//   channel | direction | signals                                   | item
//   --------+-----------+-------------------------------------------+-------------
//   req     | in        | req_valid/ready, req_data_byte, req_last_byte | one byte
//   rsp     | out       | rsp_valid/ready, rsp_crc_result           | one CRC
//   csr     | in        | csr_valid/ready, csr_index, csr_wdata     | one reg write
//
// One byte is accepted per cycle unless a last byte waits in the input
// register for a stalled rsp slot; other bytes keep flowing. A byte's eight
// CRC steps run while it sits in the input register; a last byte's CRC goes
// via the result register to rsp. csr is always ready. Reset is synchronous
// and restores the default CRC-32 settings and an idle message.
//
module programmable_crc_engine
   import pce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CRC_W-1:0]     rsp_crc_result,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CRC_W-1:0]     csr_wdata
);

   cfg_type          cfg;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_data_ff;
   logic             in_last_ff;
   logic             in_message_ff;
   logic [CRC_W-1:0] running_crc_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_ff;

   logic             out_free;
   logic             advance;
   logic [CRC_W-1:0] crc_start;
   logic [CRC_W-1:0] crc_aligned;
   logic [CRC_W-1:0] poly_aligned;
   logic [CRC_W-1:0] crc_next_aligned;
   logic [CRC_W-1:0] crc_result;

   pce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: a last byte moves on only when the result slot is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   // Start value: init at message start, else the running register
   assign crc_start    = (in_message_ff ? running_crc_ff : cfg.initial_value) & cfg.mask;
   assign crc_aligned  = crc_start << cfg.shift;
   assign poly_aligned = (cfg.polynomial & cfg.mask) << cfg.shift;

   pce_byte_step u_step (
      .crc_in        (crc_aligned),
      .data_byte     (in_data_ff),
      .reflect_input (cfg.reflect_input),
      .poly_aligned  (poly_aligned),
      .crc_out       (crc_next_aligned)
   );

   pce_finish u_finish (
      .crc_aligned    (crc_next_aligned),
      .shift          (cfg.shift),
      .mask           (cfg.mask),
      .reflect_output (cfg.reflect_output),
      .final_xor      (cfg.final_xor),
      .crc_result     (crc_result)
   );

   // Result slot
   always_comb begin
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         in_message_ff  <= 1'b0;
         running_crc_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            in_message_ff  <= !in_last_ff;
            running_crc_ff <= crc_next_aligned >> cfg.shift;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_crc_ff <= crc_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_result = rsp_crc_ff;

endmodule

// File: test/tb_programmable_crc_engine.sv
// ----------------------------------------------------------------------------
// tb_programmable_crc_engine
// Self-checking bench for the programmable CRC engine. A queue of byte items,
// register writes and drain points feeds a clocked driver; a clocked monitor
// runs a bit-serial CRC predictor on every accepted byte and checks each
// returned CRC in order. Registers are rewritten only once the engine is idle,
// sometimes with a message still open.
// ----------------------------------------------------------------------------
module tb_programmable_crc_engine;
   import pce_pkg::*;

   localparam int          ITEM_TARGET   = 1250;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          END_CYCLES    = 10;
   localparam int          REPORT_LIMIT  = 40;
   localparam longint      TIMEOUT       = 3_000_000;
   // indexes that decode to no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {CMD_BYTE, CMD_CSR, CMD_DRAIN} cmd_kind_type;

   typedef struct {
      cmd_kind_type           kind;
      logic [7:0]             data;
      logic                   last;
      logic [CSR_IDX_W-1:0]   index;
      logic [CRC_W-1:0]       wdata;
   } stim_cmd_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_data_byte  = '0;
   logic                 req_last_byte  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b1;
   logic [CRC_W-1:0]     rsp_crc_result;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [CRC_W-1:0]     csr_wdata      = '0;

   // handshakes seen at the last rising edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   stim_cmd_type     stim_queue[$];
   logic [CRC_W-1:0] crc_expect[$];
   int unsigned      bytes_queued  = 0;
   int unsigned      bytes_sent    = 0;
   int unsigned      crcs_taken    = 0;
   int unsigned      hold_cycles   = 0;
   int unsigned      stall_cycles  = 0;
   int unsigned      quiet_cycles  = 0;
   int unsigned      failures      = 0;

   // predictor copy of the settings and the message state
   logic [WIDTH_W-1:0] cfg_width;
   logic [CRC_W-1:0]   cfg_poly;
   logic [CRC_W-1:0]   cfg_init;
   logic               cfg_refin;
   logic               cfg_refout;
   logic [CRC_W-1:0]   cfg_xorout;
   logic [CRC_W-1:0]   crc_acc;
   logic               msg_open;

   programmable_crc_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_result (rsp_crc_result),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // CRC predictor
   // ------------------------------------------------------------------------

   // width in use: 0 acts as 1, anything above CRC_W as CRC_W
   function automatic int unsigned active_span();
      int unsigned w = 32'(cfg_width);
      if (w == 0) w = 1;
      if (w > CRC_W) w = CRC_W;
      return w;
   endfunction

   function automatic logic [CRC_W-1:0] span_mask(input int unsigned w);
      logic [CRC_W-1:0] one = 1;
      if (w >= CRC_W) return '1;
      return (one << w) - one;
   endfunction

   function automatic logic [CRC_W-1:0] mirror_span(input logic [CRC_W-1:0] v,
                                                    input int unsigned w);
      logic [CRC_W-1:0] r = '0;
      for (int i = 0; i < w; i++) r[w-1-i] = v[i];
      return r;
   endfunction

   // shift one byte through the register; a last byte queues the finished CRC
   task automatic absorb_byte(input logic [7:0] b, input logic last);
      int unsigned      w;
      int unsigned      pos;
      logic [CRC_W-1:0] m;
      logic [CRC_W-1:0] p;
      logic [CRC_W-1:0] c;
      logic [CRC_W-1:0] r;
      logic             fb;
      w = active_span();
      m = span_mask(w);
      p = cfg_poly & m;
      if (!msg_open) begin
         crc_acc  = cfg_init & m;
         msg_open = 1'b1;
      end
      c = crc_acc & m;
      for (int j = 0; j < 8; j++) begin
         pos = cfg_refin ? j : 7 - j;
         fb  = c[w-1] ^ b[pos];
         c   = (c << 1) & m;
         if (fb) c = c ^ p;
      end
      crc_acc = c;
      if (last) begin
         r = cfg_refout ? mirror_span(c, w) : c;
         crc_expect.push_back((r ^ cfg_xorout) & m);
         msg_open = 1'b0;
      end
   endtask

   task automatic apply_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CRC_W-1:0] value);
      case (csr_index_type'(idx))
         CSR_CRC_WIDTH:      cfg_width  = value[WIDTH_W-1:0];
         CSR_POLYNOMIAL:     cfg_poly   = value;
         CSR_INITIAL_VALUE:  cfg_init   = value;
         CSR_REFLECT_INPUT:  cfg_refin  = value[0];
         CSR_REFLECT_OUTPUT: cfg_refout = value[0];
         CSR_FINAL_XOR:      cfg_xorout = value;
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------

   // zero gaps for one stretch of 64 items out of three
   function automatic int unsigned draw_hold(input int unsigned count);
      if ((count / 64) % 3 == 0) return 0;
      return $urandom_range(0, 6);
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic last);
      stim_cmd_type c;
      c.kind  = CMD_BYTE;
      c.data  = b;
      c.last  = last;
      c.index = '0;
      c.wdata = '0;
      stim_queue.push_back(c);
      bytes_queued++;
   endtask

   task automatic push_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CRC_W-1:0] value);
      stim_cmd_type c;
      c.kind  = CMD_CSR;
      c.data  = '0;
      c.last  = 1'b0;
      c.index = idx;
      c.wdata = value;
      stim_queue.push_back(c);
   endtask

   task automatic push_drain();
      stim_cmd_type c;
      c.kind  = CMD_DRAIN;
      c.data  = '0;
      c.last  = 1'b0;
      c.index = '0;
      c.wdata = '0;
      stim_queue.push_back(c);
   endtask

   task automatic push_message(input int unsigned len);
      for (int i = 1; i <= len; i++) push_byte(8'($urandom_range(0, 255)), i == len);
   endtask

   function automatic logic [CRC_W-1:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // random value for one register, biased toward edge widths
   function automatic logic [CRC_W-1:0] pick_csr_value(input logic [CSR_IDX_W-1:0] idx);
      logic [CRC_W-1:0]   noise = $urandom();
      logic [WIDTH_W-1:0] w;
      case (csr_index_type'(idx))
         CSR_CRC_WIDTH: begin
            case ($urandom_range(0, 10))
               0:       w = WIDTH_W'(0);
               1:       w = WIDTH_W'(1);
               2:       w = WIDTH_W'(2);
               3:       w = WIDTH_W'(7);
               4:       w = WIDTH_W'(8);
               5:       w = WIDTH_W'(16);
               6:       w = WIDTH_W'(31);
               7:       w = WIDTH_W'(32);
               8:       w = WIDTH_W'(33);
               9:       w = WIDTH_W'(63);
               default: w = WIDTH_W'($urandom_range(0, 63));
            endcase
            return {noise[CRC_W-1:WIDTH_W], w};
         end
         CSR_REFLECT_INPUT, CSR_REFLECT_OUTPUT: return noise;
         default: return pick_word();
      endcase
   endfunction

   task automatic build_stimulus();
      logic [CSR_IDX_W-1:0] idx;
      // standard CRC-32 check string under the reset settings
      for (int i = 0; i < 9; i++) push_byte(8'h31 + 8'(i), i == 8);
      // one-byte messages at the byte extremes
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_drain();
      // width 0 acts as 1; extreme operands
      push_csr(CSR_CRC_WIDTH, 32'hFFFF_FFC0);
      push_csr(CSR_POLYNOMIAL, '1);
      push_csr(CSR_INITIAL_VALUE, '0);
      push_csr(CSR_REFLECT_INPUT, 32'hFFFF_FFFE);
      push_csr(CSR_REFLECT_OUTPUT, '0);
      push_csr(CSR_FINAL_XOR, '0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b1);
      // settings change with a message open; init not reloaded
      push_csr(CSR_CRC_WIDTH, 32'd8);
      push_csr(CSR_POLYNOMIAL, 32'h0000_0007);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_csr(CSR_CRC_WIDTH, 32'd63);
      push_csr(CSR_REFLECT_INPUT, 32'd1);
      push_byte(8'hC3, 1'b1);
      // writes to unused indexes change nothing
      push_csr(CSR_SPARE_LO, '1);
      push_csr(CSR_SPARE_HI, '1);
      // 16-bit CRC with wide operands masked down
      push_csr(CSR_CRC_WIDTH, 32'd16);
      push_csr(CSR_POLYNOMIAL, 32'hDEAD_1021);
      push_csr(CSR_INITIAL_VALUE, '1);
      push_csr(CSR_REFLECT_INPUT, '0);
      push_csr(CSR_REFLECT_OUTPUT, 32'd1);
      push_csr(CSR_FINAL_XOR, 32'hABCD_1234);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);

      // random phases: reconfigure, then a run of messages
      while (bytes_queued < ITEM_TARGET) begin
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 15) == 0) idx = CSR_IDX_W'($urandom_range(6, 7));
            else idx = CSR_IDX_W'($urandom_range(0, 5));
            push_csr(idx, pick_csr_value(idx));
         end
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0) push_message($urandom_range(9, 40));
            else push_message($urandom_range(1, 8));
         end
         // sometimes leave a message open across the next reconfiguration
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         if ($urandom_range(0, 9) == 0) push_drain();
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: request and register channels, changed at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic nxt_req_valid;
      logic nxt_csr_valid;
      nxt_req_valid = req_valid;
      nxt_csr_valid = csr_valid;
      if (!reset) begin
         if (req_fire) nxt_req_valid = 1'b0;
         if (csr_fire) nxt_csr_valid = 1'b0;
         // cycles spent with no byte in flight and no CRC outstanding
         if (crc_expect.size() == 0 && !nxt_req_valid) begin
            if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         if (!nxt_req_valid && !nxt_csr_valid) begin
            if (hold_cycles != 0) begin
               hold_cycles--;
            end else if (stim_queue.size() != 0) begin
               case (stim_queue[0].kind)
                  CMD_BYTE: begin
                     req_data_byte <= stim_queue[0].data;
                     req_last_byte <= stim_queue[0].last;
                     nxt_req_valid = 1'b1;
                     void'(stim_queue.pop_front());
                     bytes_sent++;
                     hold_cycles = draw_hold(bytes_sent);
                  end
                  CMD_CSR: begin
                     if (quiet_cycles >= SETTLE_CYCLES) begin
                        csr_index     <= stim_queue[0].index;
                        csr_wdata     <= stim_queue[0].wdata;
                        nxt_csr_valid = 1'b1;
                        void'(stim_queue.pop_front());
                     end
                  end
                  CMD_DRAIN: begin
                     if (crc_expect.size() == 0) void'(stim_queue.pop_front());
                  end
                  default: void'(stim_queue.pop_front());
               endcase
            end
         end
      end
      req_valid <= nxt_req_valid;
      csr_valid <= nxt_csr_valid;
   end

   // Receiver: a fresh stall length, possibly zero, drawn after every CRC taken
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) stall_cycles = draw_hold(crcs_taken);
         if (stall_cycles != 0) begin
            stall_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on accepted bytes, check CRCs in order
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [CRC_W-1:0] want;
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      csr_fire = csr_valid && csr_ready;
      if (reset) begin
         cfg_width  = WIDTH_W'(CRC_W);
         cfg_poly   = POLY_RST;
         cfg_init   = INIT_RST;
         cfg_refin  = 1'b1;
         cfg_refout = 1'b1;
         cfg_xorout = FXOR_RST;
         crc_acc    = '0;
         msg_open   = 1'b0;
         req_fire   = 1'b0;
         rsp_fire   = 1'b0;
         csr_fire   = 1'b0;
      end else begin
         if (csr_fire) apply_csr_write(csr_index, csr_wdata);
         if (req_fire) absorb_byte(req_data_byte, req_last_byte);
         if (rsp_fire) begin
            crcs_taken++;
            if (crc_expect.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: crc_result expected none, actual %08h",
                           $time, rsp_crc_result);
            end else begin
               want = crc_expect.pop_front();
               if (rsp_crc_result !== want) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%0t: crc_result expected %08h, actual %08h",
                              $time, want, rsp_crc_result);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, run the queue, drain, report
   // ------------------------------------------------------------------------
   initial begin
      build_stimulus();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (stim_queue.size() != 0 || req_valid || csr_valid || crc_expect.size() != 0);
      repeat (END_CYCLES) @(posedge clock);
      if (crc_expect.size() != 0) begin
         failures++;
         $display("%0t: crc_result expected %08h, actual none (%0d missing)",
                  $time, crc_expect[0], crc_expect.size());
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #(TIMEOUT);
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
